// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: rtl/hsvn_pkg.sv
// ----------------------------------------------------------------------------
// hsvn_pkg
// Types and fixed constants of the HSV histogram with L2 normalization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsvn_pkg;

   // One RGB pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } req_type;

   // One normalized bin
   typedef struct packed {
      logic [5:0]  bin_index;
      logic [15:0] bin_value;
      logic        last_bin;
   } rsp_type;

   // Classified pixel as queued between front and back
   typedef struct packed {
      logic [5:0] bin;
      logic       last;
   } item_type;

   // Queue status toward the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Hue arithmetic is done in hundredths of a degree
   localparam logic signed [25:0] HUE_SECTOR  = 26'sd6000;
   localparam logic signed [25:0] HUE_GREEN   = 26'sd12000;
   localparam logic signed [25:0] HUE_BLUE    = 26'sd24000;
   localparam logic signed [25:0] HUE_CIRCLE  = 26'sd36000;
   localparam int                 HUE_RANGE   = 180;
   localparam int                 COMP_RANGE  = 256;
   // 2 * 65535, saturation numerator scale
   localparam logic [26:0]        SAT_SCALE2  = 27'd131070;

   // Normalization: 16 result bits, right-hand side scaled by 2^34
   localparam int RES_BITS  = 16;
   localparam int RHS_SHIFT = 34;
   localparam int K2_W      = 34;
   localparam int CHUNK_W   = 16;

   typedef enum logic [7:0] {
      ST_COUNT = 8'b0000_0001,
      ST_WAIT  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_LOAD  = 8'b0000_1000,
      ST_K2    = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_CMP   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/hsvn_ram.sv
// ----------------------------------------------------------------------------
// hsvn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvn_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/hsvn_front.sv
// ----------------------------------------------------------------------------
// hsvn_front
// Two-stage pixel classifier: RGB to HSV sector terms, then bin thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvn_front #(
   parameter int HUE_BINS = 4,
   parameter int SAT_BINS = 4,
   parameter int VAL_BINS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire hsvn_pkg::req_type         req_data,
   input  wire hsvn_pkg::queue_status_type q_status,
   output logic                           push,
   output hsvn_pkg::item_type             push_item
);

   logic              en;
   logic              p1_valid_ff;
   hsvn_pkg::req_type p1_ff;
   logic              p2_valid_ff;
   logic [23:0]       n_ff;
   logic [7:0]        d_ff;
   logic [7:0]        mx_ff;
   logic              last_ff;

   logic [7:0]         mx, mn, d;
   logic signed [25:0] rs, gs, bs, ds, n;
   logic [25:0]        hnum;
   logic [26:0]        snum;
   logic               grey;
   logic [3:1]         hit_h, hit_s, hit_v;
   logic [2:0]         hb, sb, vb;

   assign en        = !q_status.full;
   assign req_stall = !en;

   // Stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= req_valid;
      end
      if (en) begin
         p1_ff <= req_data;
      end
   end

   // Max, min and hue numerator in hundredths of a degree
   always_comb begin
      mx = p1_ff.red;
      mn = p1_ff.red;
      if (p1_ff.green > mx) mx = p1_ff.green;
      if (p1_ff.blue > mx)  mx = p1_ff.blue;
      if (p1_ff.green < mn) mn = p1_ff.green;
      if (p1_ff.blue < mn)  mn = p1_ff.blue;
      d  = mx - mn;
      rs = {18'd0, p1_ff.red};
      gs = {18'd0, p1_ff.green};
      bs = {18'd0, p1_ff.blue};
      ds = {18'd0, d};
      if (p1_ff.red == mx) begin
         n = hsvn_pkg::HUE_SECTOR * (gs - bs);
      end else if (p1_ff.green == mx) begin
         n = hsvn_pkg::HUE_GREEN * ds + hsvn_pkg::HUE_SECTOR * (bs - rs);
      end else begin
         n = hsvn_pkg::HUE_BLUE * ds + hsvn_pkg::HUE_SECTOR * (rs - gs);
      end
      if (n < 0) begin
         n = n + hsvn_pkg::HUE_CIRCLE * ds;
      end
   end

   // Stage 2: HSV terms
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         n_ff    <= n[23:0];
         d_ff    <= d;
         mx_ff   <= mx;
         last_ff <= p1_ff.last_pixel;
      end
   end

   assign grey = (d_ff == 8'd0);
   assign hnum = {1'b0, n_ff, 1'b0} + 26'(d_ff);
   assign snum = 27'(d_ff) * hsvn_pkg::SAT_SCALE2 + 27'(mx_ff);

   // Bin boundaries as compares against constant multiples
   for (genvar k = 1; k <= 3; k++) begin : g_thr
      localparam int TH = (hsvn_pkg::HUE_RANGE * k + HUE_BINS - 1) / HUE_BINS;
      localparam int UH = 100 * (2 * TH - 1);
      localparam int TS = (hsvn_pkg::COMP_RANGE * k + SAT_BINS - 1) / SAT_BINS;
      localparam int TV = (hsvn_pkg::COMP_RANGE * k + VAL_BINS - 1) / VAL_BINS;
      if (k < HUE_BINS) begin : g_h
         assign hit_h[k] = !grey && (hnum >= 26'(d_ff) * 26'(2 * UH));
      end else begin : g_hn
         assign hit_h[k] = 1'b0;
      end
      if (k < SAT_BINS) begin : g_s
         assign hit_s[k] = !grey && (snum >= 27'(mx_ff) * 27'(512 * TS));
      end else begin : g_sn
         assign hit_s[k] = 1'b0;
      end
      if (k < VAL_BINS) begin : g_v
         assign hit_v[k] = (mx_ff >= 8'(TV));
      end else begin : g_vn
         assign hit_v[k] = 1'b0;
      end
   end

   assign hb = 3'(hit_h[1]) + 3'(hit_h[2]) + 3'(hit_h[3]);
   assign sb = 3'(hit_s[1]) + 3'(hit_s[2]) + 3'(hit_s[3]);
   assign vb = 3'(hit_v[1]) + 3'(hit_v[2]) + 3'(hit_v[3]);

   assign push           = p2_valid_ff && en;
   assign push_item.bin  = (6'(hb) * 6'(SAT_BINS) + 6'(sb)) * 6'(VAL_BINS) + 6'(vb);
   assign push_item.last = last_ff;

endmodule

`default_nettype wire

// File: rtl/hsvn_queue.sv
// ----------------------------------------------------------------------------
// hsvn_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvn_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire hsvn_pkg::item_type        push_item,
   output hsvn_pkg::queue_status_type     status,
   input  wire logic                      pop,
   output hsvn_pkg::item_type             head
);

   hsvn_pkg::item_type               slot_ff [hsvn_pkg::QUEUE_DEPTH];
   logic [hsvn_pkg::QPTR_W-1:0]      wr_ff, rd_ff;
   logic [hsvn_pkg::QPTR_W:0]        cnt_ff;

   assign status.full  = (cnt_ff == (hsvn_pkg::QPTR_W+1)'(hsvn_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head         = slot_ff[rd_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (hsvn_pkg::QPTR_W+1)'(push) - (hsvn_pkg::QPTR_W+1)'(pop);
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hsvn_back.sv
// ----------------------------------------------------------------------------
// hsvn_back
// Bin counting with read-modify-write, then the per-bin normalization walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvn_back #(
   parameter int NBINS      = 64,
   parameter int COUNT_BITS = 21
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hsvn_pkg::queue_status_type q_status,
   input  wire hsvn_pkg::item_type        head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output hsvn_pkg::rsp_type              rsp_data
);

   localparam int AW     = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam int SUM_W  = (2 * COUNT_BITS + 6 > 64) ? 64 : 2 * COUNT_BITS + 6;
   localparam int NCH    = (SUM_W + hsvn_pkg::CHUNK_W - 1) / hsvn_pkg::CHUNK_W;
   localparam int SPAD_W = NCH * hsvn_pkg::CHUNK_W;
   localparam int ACC_W  = hsvn_pkg::K2_W + SPAD_W;
   localparam int RHS_W  = 2 * COUNT_BITS + hsvn_pkg::RHS_SHIFT;
   localparam int CMP_W  = (ACC_W > RHS_W) ? ACC_W : RHS_W;
   localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   hsvn_pkg::state_type state_ff, state_in;

   // Counting path
   logic [NBINS-1:0]      vld_ff;
   logic                  vq_ff;
   logic                  s1_valid_ff;
   logic [AW-1:0]         s1_bin_ff;
   logic                  fwd_valid_ff;
   logic [AW-1:0]         fwd_bin_ff;
   logic [COUNT_BITS-1:0] fwd_val_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [COUNT_BITS-1:0] ram_q, cur, nxt;
   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [SUM_W:0]        sum_add;

   // Normalization path
   logic [5:0]                       idx_ff;
   logic [2*COUNT_BITS-1:0]          c2_ff;
   logic [3:0]                       bit_ff;
   logic [hsvn_pkg::RES_BITS-1:0]    q_ff, t_ff, t;
   logic [hsvn_pkg::K2_W-1:0]        k2_ff;
   logic [SPAD_W-1:0]                s_sh_ff;
   logic [ACC_W-1:0]                 acc_ff;
   logic [CNT_W-1:0]                 chunk_ff;
   logic [hsvn_pkg::RES_BITS:0]      k;
   logic [hsvn_pkg::K2_W+hsvn_pkg::CHUNK_W-1:0] mac_prod;
   logic [COUNT_BITS-1:0]            c_rd;
   logic                             fits;
   logic                             can_load;

   assign pop      = (state_ff == hsvn_pkg::ST_COUNT) && !q_status.empty;
   assign rd_addr  = (state_ff == hsvn_pkg::ST_COUNT) ? head.bin[AW-1:0] : idx_ff[AW-1:0];
   assign can_load = !rsp_valid || !rsp_stall;

   hsvn_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_bin_ff),
      .wr_data (nxt),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Current count of the bin in stage 1: forwarded from the previous write, else the RAM word or zero
   always_comb begin
      if (fwd_valid_ff && (fwd_bin_ff == s1_bin_ff)) begin
         cur = fwd_val_ff;
      end else if (vq_ff) begin
         cur = ram_q;
      end else begin
         cur = '0;
      end
      wr_en   = s1_valid_ff && (cur != COUNT_MAX);
      nxt     = (cur != COUNT_MAX) ? cur + 1'b1 : cur;
      sum_add = {1'b0, sum_ff} + (SUM_W+1)'({cur, 1'b1});
      c_rd    = vq_ff ? ram_q : '0;
   end

   // Normalization search terms
   assign t        = q_ff | (hsvn_pkg::RES_BITS'(1) << bit_ff);
   assign k        = {t, 1'b0} - 1'b1;
   assign mac_prod = k2_ff * s_sh_ff[SPAD_W-1 -: hsvn_pkg::CHUNK_W];
   assign fits     = (CMP_W'(acc_ff) <= (CMP_W'(c2_ff) << hsvn_pkg::RHS_SHIFT));

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsvn_pkg::ST_COUNT: if (pop && head.last) state_in = hsvn_pkg::ST_WAIT;
         hsvn_pkg::ST_WAIT:  state_in = hsvn_pkg::ST_READ;
         hsvn_pkg::ST_READ:  state_in = hsvn_pkg::ST_LOAD;
         hsvn_pkg::ST_LOAD:  state_in = (sum_ff == '0) ? hsvn_pkg::ST_OUT : hsvn_pkg::ST_K2;
         hsvn_pkg::ST_K2:    state_in = hsvn_pkg::ST_MUL;
         hsvn_pkg::ST_MUL:   if (chunk_ff == '0) state_in = hsvn_pkg::ST_CMP;
         hsvn_pkg::ST_CMP:   state_in = (bit_ff == 4'd0) ? hsvn_pkg::ST_OUT : hsvn_pkg::ST_K2;
         hsvn_pkg::ST_OUT: begin
            if (can_load) begin
               state_in = (idx_ff == 6'(NBINS - 1)) ? hsvn_pkg::ST_COUNT : hsvn_pkg::ST_READ;
            end
         end
         default: state_in = hsvn_pkg::ST_COUNT;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsvn_pkg::ST_COUNT;
         vld_ff       <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= pop;
         fwd_valid_ff <= s1_valid_ff;
         if (wr_en) begin
            vld_ff[s1_bin_ff] <= 1'b1;
            sum_ff <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         end
         if (state_ff == hsvn_pkg::ST_OUT && can_load) begin
            rsp_valid <= 1'b1;
            // Frame done: empty the histogram
            if (idx_ff == 6'(NBINS - 1)) begin
               vld_ff <= '0;
               sum_ff <= '0;
            end
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      vq_ff      <= vld_ff[rd_addr];
      s1_bin_ff  <= head.bin[AW-1:0];
      fwd_bin_ff <= s1_bin_ff;
      fwd_val_ff <= nxt;
      case (state_ff)
         hsvn_pkg::ST_WAIT: begin
            idx_ff <= '0;
         end
         hsvn_pkg::ST_LOAD: begin
            c2_ff  <= c_rd * c_rd;
            q_ff   <= '0;
            bit_ff <= 4'(hsvn_pkg::RES_BITS - 1);
         end
         hsvn_pkg::ST_K2: begin
            t_ff     <= t;
            k2_ff    <= k * k;
            s_sh_ff  <= SPAD_W'(sum_ff);
            acc_ff   <= '0;
            chunk_ff <= CNT_W'(NCH - 1);
         end
         hsvn_pkg::ST_MUL: begin
            acc_ff   <= (acc_ff << hsvn_pkg::CHUNK_W) + ACC_W'(mac_prod);
            s_sh_ff  <= s_sh_ff << hsvn_pkg::CHUNK_W;
            chunk_ff <= chunk_ff - 1'b1;
         end
         hsvn_pkg::ST_CMP: begin
            if (fits) q_ff <= t_ff;
            bit_ff <= bit_ff - 1'b1;
         end
         hsvn_pkg::ST_OUT: begin
            if (can_load) begin
               rsp_data.bin_index <= idx_ff;
               rsp_data.bin_value <= q_ff;
               rsp_data.last_bin  <= (idx_ff == 6'(NBINS - 1));
               idx_ff             <= idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/hsv_histogram_l2_normalize_top.sv
// ----------------------------------------------------------------------------
// hsv_histogram_l2_normalize_top
// HSV color histogram of a frame, emitted L2-normalized in Q0.16 per bin.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload            Handshake
//   req_     in         RGB pixel + last   req_valid / req_stall
//   rsp_     out        bin, value, last   rsp_valid / rsp_stall
//
// Pixels are taken one per cycle while the queue is not full; a pixel's count is written
// after two classifier stages, the queue, then the read-modify-write.
// After the last pixel the bins are normalized in turn; the shared multiply-accumulate
// runs one result bit at a time over NCH, the number of 16-bit slices of the square
// sum (3 at 21-bit counts).
// Reset is synchronous; no clearing pass, the counters use valid bits.
// req_stall rises while the 4-entry queue is full, as during the walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_histogram_l2_normalize_top #(
   parameter int HUE_BINS   = 4,
   parameter int SAT_BINS   = 4,
   parameter int VAL_BINS   = 4,
   parameter int COUNT_BITS = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hsvn_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hsvn_pkg::rsp_type      rsp_data
);

   localparam int NBINS = HUE_BINS * SAT_BINS * VAL_BINS;

   hsvn_pkg::queue_status_type q_status;
   hsvn_pkg::item_type         push_item, head;
   logic                       push, pop;

   hsvn_front #(.HUE_BINS(HUE_BINS), .SAT_BINS(SAT_BINS), .VAL_BINS(VAL_BINS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   hsvn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .status    (q_status),
      .pop       (pop),
      .head      (head)
   );

   hsvn_back #(.NBINS(NBINS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/hsvn_checker.sv
// ----------------------------------------------------------------------------
// hsvn_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsvn_checker #(
   parameter int NBINS = 64
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire hsvn_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire hsvn_pkg::rsp_type rsp_data
);

   logic top_idx;
   assign top_idx = (rsp_data.bin_index == 6'(NBINS - 1));

   // A stalled response stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   // Marker of the final bin goes with the top index only
   `ASSERT_CLK(a_last_idx, clock, reset, rsp_valid |-> (rsp_data.last_bin == top_idx))
   // A stalled response keeps its payload
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data))
   // Reset empties the output register
   `ASSERT_CLK_ALWAYS(a_reset, clock, reset |=> !rsp_valid)

endmodule

bind hsv_histogram_l2_normalize_top hsvn_checker #(
   .NBINS(HUE_BINS * SAT_BINS * VAL_BINS)
) u_hsvn_checker (.*);

`default_nettype wire
